// File: hdl/rv64i_integer_core_step_defines.svh
// Assertion macros for the RV64I step core.
// Used by the top level; expects clk and arst_n in scope.
`ifndef RV64I_INTEGER_CORE_STEP_DEFINES_SVH
`define RV64I_INTEGER_CORE_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define RVI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rvi assertion failed");
`define RVI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rvi assertion failed");
`else
`define RVI_ASSERT_IMP(lbl, ante, cons)
`define RVI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/rvi_pkg.sv
// Shared types and constants of the RV64I step core.
// No dependencies.
package rvi_pkg;
	localparam int unsigned MEM_BYTES = 65536;
	localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);

	typedef logic [MEM_AW-1:0] mem_addr_t;

	localparam logic [1:0] FN_EXEC   = 2'd0;
	localparam logic [1:0] FN_HWRITE = 2'd1;
	localparam logic [1:0] FN_HREAD  = 2'd2;

	typedef enum logic [1:0] {IK_EXEC, IK_HWRITE, IK_HREAD, IK_NONE} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [15:0] host_addr;
		logic [63:0] host_data;
	} item_t;

	typedef struct packed {
		logic        ok;
		logic        cause;
		logic [63:0] pc_now;
		logic [63:0] read_data;
		logic [4:0]  wb_index;
		logic [63:0] wb_value;
	} result_t;

	localparam logic [6:0] OPC_LUI     = 7'h37;
	localparam logic [6:0] OPC_AUIPC   = 7'h17;
	localparam logic [6:0] OPC_JAL     = 7'h6F;
	localparam logic [6:0] OPC_JALR    = 7'h67;
	localparam logic [6:0] OPC_BRANCH  = 7'h63;
	localparam logic [6:0] OPC_LOAD    = 7'h03;
	localparam logic [6:0] OPC_STORE   = 7'h23;
	localparam logic [6:0] OPC_OPIMM   = 7'h13;
	localparam logic [6:0] OPC_OP      = 7'h33;
	localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
	localparam logic [6:0] OPC_OP32    = 7'h3B;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_LB   = 3'd0;
	localparam logic [2:0] F3_LH   = 3'd1;
	localparam logic [2:0] F3_LW   = 3'd2;
	localparam logic [2:0] F3_BAD  = 3'd7;
	localparam logic [2:0] F3_JALR = 3'd0;

	localparam logic [6:0] F7_BASE  = 7'h00;
	localparam logic [6:0] F7_ALT   = 7'h20;
	localparam logic [5:0] TOP6_SRL = 6'h00;
	localparam logic [5:0] TOP6_SRA = 6'h10;
endpackage

// File: hdl/rv64i_integer_core_step.sv
// RV64I step core: queued front end, byte-serial execution engine, result queue.
// After reset the 64 KiB memory is cleared one byte a cycle, and full stays high
// until the clear is done. The memory is byte-wide, with one write and one read port,
// which sets the speed: an executed instruction fetches four bytes, reads two registers,
// executes and hands off its result; a load or store then moves its n bytes one by one,
// and a host read or write moves eight bytes. Two-entry queues on both sides let a
// new word be pushed while a finished result still waits to be popped.
`include "rv64i_integer_core_step_defines.svh"
module rv64i_integer_core_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic [15:0] host_addr,
	input  logic [63:0] host_data,
	output logic        empty,
	input  logic        pop,
	output logic        ok,
	output logic        cause,
	output logic [63:0] pc_now,
	output logic [63:0] read_data,
	output logic [4:0]  wb_index,
	output logic [63:0] wb_value
);
	rvi_pkg::item_t   item;
	rvi_pkg::result_t res, head;
	logic             item_valid, item_take, res_push, res_full, clearing;

	rvi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.hold       (clearing),
		.func       (func),
		.host_addr  (host_addr),
		.host_data  (host_data),
		.full       (full),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	rvi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res),
		.clearing   (clearing)
	);

	rvi_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	assign ok        = head.ok;
	assign cause     = head.cause;
	assign pc_now    = head.pc_now;
	assign read_data = head.read_data;
	assign wb_index  = head.wb_index;
	assign wb_value  = head.wb_value;

	`RVI_ASSERT_IMP(a_push_room, res_push, !res_full)
	`RVI_ASSERT_IMP(a_take_valid, item_take, item_valid)
	`RVI_ASSERT_IMP(a_trap_shape, !empty && !ok, cause && wb_index == 5'd0)
	`RVI_ASSERT_IMP(a_wb_zero, !empty && wb_index == 5'd0, wb_value == 64'd0)
endmodule

// File: hdl/rvi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rvi_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: hdl/rvi_front.sv
// Front end: accepts words, classifies the function code, two-entry queue.
// Depends on rvi_pkg.
module rvi_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                hold,
	input  logic [1:0]          func,
	input  logic [15:0]         host_addr,
	input  logic [63:0]         host_data,
	output logic                full,
	output logic                item_valid,
	output rvi_pkg::item_t      item,
	input  logic                item_take
);
	rvi_pkg::item_t slot_q [2];
	rvi_pkg::item_t new_c;
	logic           wr_q, rd_q;
	logic [1:0]     count_q;
	logic           do_push, do_pop;

	always_comb begin
		new_c.host_addr = host_addr;
		new_c.host_data = host_data;
		unique case (func)
			rvi_pkg::FN_EXEC:   new_c.kind = rvi_pkg::IK_EXEC;
			rvi_pkg::FN_HWRITE: new_c.kind = rvi_pkg::IK_HWRITE;
			rvi_pkg::FN_HREAD:  new_c.kind = rvi_pkg::IK_HREAD;
			default:            new_c.kind = rvi_pkg::IK_NONE;
		endcase
	end

	assign full       = hold || (count_q == 2'd2);
	assign do_push    = push && !full;
	assign do_pop     = item_take && (count_q != 2'd0);
	assign item_valid = (count_q != 2'd0);
	assign item       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= new_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

// File: hdl/rvi_resq.sv
// Result queue: two entries between the execution engine and the result port.
// Depends on rvi_pkg.
module rvi_resq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_push,
	input  rvi_pkg::result_t  res,
	output logic              res_full,
	output logic              empty,
	input  logic              pop,
	output rvi_pkg::result_t  head
);
	rvi_pkg::result_t slot_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       count_q;
	logic             do_push, do_pop;

	assign res_full = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;
	assign head     = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

// File: hdl/rvi_back.sv
// Execution engine: byte-serial memory sequencer, register file and ALU.
// Depends on rvi_pkg and rvi_ram.
module rvi_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  rvi_pkg::item_t    item,
	output logic              item_take,
	input  logic              res_full,
	output logic              res_push,
	output rvi_pkg::result_t  res,
	output logic              clearing
);
	typedef enum logic [7:0] {
		ST_CLEAR   = 8'b00000001,
		ST_IDLE    = 8'b00000010,
		ST_BYTE_RD = 8'b00000100,
		ST_BYTE_WR = 8'b00001000,
		ST_RS1     = 8'b00010000,
		ST_RS2     = 8'b00100000,
		ST_EXEC    = 8'b01000000,
		ST_DONE    = 8'b10000000
	} state_t;

	typedef enum logic [1:0] {BK_INSN, BK_DATA, BK_HOST} byte_kind_t;

	function automatic logic [63:0] sext32(input logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	state_t              state_q;
	byte_kind_t          bk_q;
	logic [63:0]         pc_q;
	logic [31:0]         rvalid_q;
	rvi_pkg::mem_addr_t  clr_q;
	logic [3:0]          cnt_q, n_q;
	logic [63:0]         base_q, wdat_q, acc_q, a_q;
	logic                inr_q;
	logic [31:0]         insn_q;
	rvi_pkg::result_t    res_q, res_c;

	logic [63:0]         addr_c, acc_nx, pc4, b_c, ld_res;
	logic                in_range, rd_last, wr_last;
	logic [7:0]          byte_c;

	logic                mem_we;
	rvi_pkg::mem_addr_t  mem_waddr;
	logic [7:0]          mem_wdata, mem_rdata;

	logic                rf_we;
	logic [4:0]          rf_waddr, rf_raddr;
	logic [63:0]         rf_wdata, rf_rdata;

	logic [6:0]          opc, f7;
	logic [4:0]          rd;
	logic [2:0]          f3;
	logic [5:0]          top6;
	logic [63:0]         immi, immu, immj, immb, imms;
	logic                ex_illegal, ex_wr, ex_load, ex_store, br_take;
	logic [63:0]         ex_res, ex_npc, ex_base;
	logic [3:0]          ex_n;

	rvi_ram #(.WIDTH(8), .DEPTH(rvi_pkg::MEM_BYTES)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (addr_c[rvi_pkg::MEM_AW-1:0]),
		.rdata (mem_rdata)
	);

	rvi_ram #(.WIDTH(64), .DEPTH(32)) u_regs (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.raddr (rf_raddr),
		.rdata (rf_rdata)
	);

	assign pc4      = pc_q + 64'd4;
	assign addr_c   = base_q + {60'd0, cnt_q};
	assign in_range = addr_c < 64'(rvi_pkg::MEM_BYTES);
	assign rd_last  = (cnt_q == n_q);
	assign wr_last  = (cnt_q == n_q - 4'd1);
	assign byte_c   = inr_q ? mem_rdata : 8'h00;

	// read data is registered in the RAM, so it trails the address
	always_comb begin
		acc_nx = acc_q;
		if (cnt_q != 4'd0) begin
			acc_nx[{3'(cnt_q - 4'd1), 3'b000} +: 8] = byte_c;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_c[rvi_pkg::MEM_AW-1:0];
		mem_wdata = wdat_q[{cnt_q[2:0], 3'b000} +: 8];
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = 8'h00;
		end else if (state_q == ST_BYTE_WR) begin
			mem_we = in_range;
		end
	end

	// never-written registers (x0 included) read as zero
	assign rf_raddr = (state_q == ST_RS1) ? insn_q[19:15] : insn_q[24:20];
	assign b_c      = rvalid_q[insn_q[24:20]] ? rf_rdata : 64'd0;

	assign opc  = insn_q[6:0];
	assign rd   = insn_q[11:7];
	assign f3   = insn_q[14:12];
	assign f7   = insn_q[31:25];
	assign top6 = insn_q[31:26];
	assign immi = {{52{insn_q[31]}}, insn_q[31:20]};
	assign immu = {{32{insn_q[31]}}, insn_q[31:12], 12'd0};
	assign immj = {{43{insn_q[31]}}, insn_q[31], insn_q[19:12], insn_q[20],
		insn_q[30:21], 1'b0};
	assign immb = {{51{insn_q[31]}}, insn_q[31], insn_q[7], insn_q[30:25],
		insn_q[11:8], 1'b0};
	assign imms = {{52{insn_q[31]}}, insn_q[31:25], insn_q[11:7]};

	always_comb begin
		ex_illegal = 1'b0;
		ex_wr      = 1'b1;
		ex_load    = 1'b0;
		ex_store   = 1'b0;
		ex_res     = 64'd0;
		ex_npc     = pc4;
		ex_base    = a_q + immi;
		ex_n       = 4'd1 << f3[1:0];
		br_take    = 1'b0;
		unique case (opc)
			rvi_pkg::OPC_LUI:   ex_res = immu;
			rvi_pkg::OPC_AUIPC: ex_res = pc_q + immu;
			rvi_pkg::OPC_JAL: begin
				ex_res = pc4;
				ex_npc = pc_q + immj;
			end
			rvi_pkg::OPC_JALR: begin
				ex_illegal = (f3 != rvi_pkg::F3_JALR);
				ex_res     = pc4;
				ex_npc     = (a_q + immi) & ~64'd1;
			end
			rvi_pkg::OPC_BRANCH: begin
				ex_wr = 1'b0;
				case (f3)
					rvi_pkg::F3_BEQ:  br_take = (a_q == b_c);
					rvi_pkg::F3_BNE:  br_take = (a_q != b_c);
					rvi_pkg::F3_BLT:  br_take = ($signed(a_q) < $signed(b_c));
					rvi_pkg::F3_BGE:  br_take = !($signed(a_q) < $signed(b_c));
					rvi_pkg::F3_BLTU: br_take = (a_q < b_c);
					rvi_pkg::F3_BGEU: br_take = (a_q >= b_c);
					default:          ex_illegal = 1'b1;
				endcase
				if (br_take) begin
					ex_npc = pc_q + immb;
				end
			end
			rvi_pkg::OPC_LOAD: begin
				ex_wr      = 1'b0;
				ex_load    = 1'b1;
				ex_illegal = (f3 == rvi_pkg::F3_BAD);
			end
			rvi_pkg::OPC_STORE: begin
				ex_wr      = 1'b0;
				ex_store   = 1'b1;
				ex_illegal = f3[2];
				ex_base    = a_q + imms;
			end
			rvi_pkg::OPC_OPIMM: begin
				case (f3)
					rvi_pkg::F3_ADD:  ex_res = a_q + immi;
					rvi_pkg::F3_SLT:  ex_res = {63'd0, $signed(a_q) < $signed(immi)};
					rvi_pkg::F3_SLTU: ex_res = {63'd0, a_q < immi};
					rvi_pkg::F3_XOR:  ex_res = a_q ^ immi;
					rvi_pkg::F3_OR:   ex_res = a_q | immi;
					rvi_pkg::F3_AND:  ex_res = a_q & immi;
					rvi_pkg::F3_SLL: begin
						ex_illegal = (top6 != rvi_pkg::TOP6_SRL);
						ex_res     = a_q << insn_q[25:20];
					end
					default: begin
						if (top6 == rvi_pkg::TOP6_SRL) begin
							ex_res = a_q >> insn_q[25:20];
						end else if (top6 == rvi_pkg::TOP6_SRA) begin
							ex_res = 64'($signed(a_q) >>> insn_q[25:20]);
						end else begin
							ex_illegal = 1'b1;
						end
					end
				endcase
			end
			rvi_pkg::OPC_OP: begin
				if (f7 == rvi_pkg::F7_ALT) begin
					if (f3 == rvi_pkg::F3_ADD) begin
						ex_res = a_q - b_c;
					end else if (f3 == rvi_pkg::F3_SR) begin
						ex_res = 64'($signed(a_q) >>> b_c[5:0]);
					end else begin
						ex_illegal = 1'b1;
					end
				end else if (f7 == rvi_pkg::F7_BASE) begin
					case (f3)
						rvi_pkg::F3_ADD:  ex_res = a_q + b_c;
						rvi_pkg::F3_SLL:  ex_res = a_q << b_c[5:0];
						rvi_pkg::F3_SLT:  ex_res = {63'd0, $signed(a_q) < $signed(b_c)};
						rvi_pkg::F3_SLTU: ex_res = {63'd0, a_q < b_c};
						rvi_pkg::F3_XOR:  ex_res = a_q ^ b_c;
						rvi_pkg::F3_SR:   ex_res = a_q >> b_c[5:0];
						rvi_pkg::F3_OR:   ex_res = a_q | b_c;
						default:          ex_res = a_q & b_c;
					endcase
				end else begin
					ex_illegal = 1'b1;
				end
			end
			rvi_pkg::OPC_OPIMM32: begin
				if (f3 == rvi_pkg::F3_ADD) begin
					ex_res = sext32(a_q + immi);
				end else if (f3 == rvi_pkg::F3_SLL && f7 == rvi_pkg::F7_BASE) begin
					ex_res = sext32({32'd0, a_q[31:0] << insn_q[24:20]});
				end else if (f3 == rvi_pkg::F3_SR && f7 == rvi_pkg::F7_BASE) begin
					ex_res = sext32({32'd0, a_q[31:0] >> insn_q[24:20]});
				end else if (f3 == rvi_pkg::F3_SR && f7 == rvi_pkg::F7_ALT) begin
					ex_res = 64'($signed(sext32(a_q)) >>> insn_q[24:20]);
				end else begin
					ex_illegal = 1'b1;
				end
			end
			rvi_pkg::OPC_OP32: begin
				if (f3 == rvi_pkg::F3_ADD && f7 == rvi_pkg::F7_BASE) begin
					ex_res = sext32(a_q + b_c);
				end else if (f3 == rvi_pkg::F3_ADD && f7 == rvi_pkg::F7_ALT) begin
					ex_res = sext32(a_q - b_c);
				end else if (f3 == rvi_pkg::F3_SLL && f7 == rvi_pkg::F7_BASE) begin
					ex_res = sext32({32'd0, a_q[31:0] << b_c[4:0]});
				end else if (f3 == rvi_pkg::F3_SR && f7 == rvi_pkg::F7_BASE) begin
					ex_res = sext32({32'd0, a_q[31:0] >> b_c[4:0]});
				end else if (f3 == rvi_pkg::F3_SR && f7 == rvi_pkg::F7_ALT) begin
					ex_res = 64'($signed(sext32(a_q)) >>> b_c[4:0]);
				end else begin
					ex_illegal = 1'b1;
				end
			end
			default: ex_illegal = 1'b1;
		endcase
	end

	always_comb begin
		case (f3)
			rvi_pkg::F3_LB: ld_res = {{56{acc_nx[7]}}, acc_nx[7:0]};
			rvi_pkg::F3_LH: ld_res = {{48{acc_nx[15]}}, acc_nx[15:0]};
			rvi_pkg::F3_LW: ld_res = sext32(acc_nx);
			default:        ld_res = acc_nx;
		endcase
	end

	always_comb begin
		rf_we    = 1'b0;
		rf_waddr = rd;
		rf_wdata = ex_res;
		if (state_q == ST_EXEC) begin
			rf_we = !ex_illegal && ex_wr && (rd != 5'd0);
		end else if (state_q == ST_BYTE_RD && bk_q == BK_DATA && rd_last) begin
			rf_we    = (rd != 5'd0);
			rf_wdata = ld_res;
		end
	end

	always_comb begin
		res_c        = '0;
		res_c.ok     = 1'b1;
		res_c.pc_now = pc_q;
		case (state_q)
			ST_BYTE_RD: begin
				if (bk_q == BK_HOST) begin
					res_c.read_data = acc_nx;
				end else if (bk_q == BK_DATA) begin
					res_c.pc_now = pc4;
					if (rd != 5'd0) begin
						res_c.wb_index = rd;
						res_c.wb_value = ld_res;
					end
				end
			end
			ST_BYTE_WR: begin
				if (bk_q == BK_DATA) begin
					res_c.pc_now = pc4;
				end
			end
			ST_EXEC: begin
				if (ex_illegal) begin
					res_c.ok    = 1'b0;
					res_c.cause = 1'b1;
				end else begin
					res_c.pc_now = ex_npc;
					if (ex_wr && rd != 5'd0) begin
						res_c.wb_index = rd;
						res_c.wb_value = ex_res;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q != ST_DONE) begin
			res_q <= res_c;
		end
		unique case (state_q)
			ST_IDLE: begin
				acc_q  <= 64'd0;
				inr_q  <= 1'b0;
				wdat_q <= item.host_data;
				if (item.kind == rvi_pkg::IK_EXEC) begin
					base_q <= pc_q;
					n_q    <= 4'd4;
					bk_q   <= BK_INSN;
				end else begin
					base_q <= {48'd0, item.host_addr};
					n_q    <= 4'd8;
					bk_q   <= BK_HOST;
				end
			end
			ST_BYTE_RD: begin
				acc_q <= acc_nx;
				inr_q <= in_range;
				if (rd_last && bk_q == BK_INSN) begin
					insn_q <= acc_nx[31:0];
				end
			end
			ST_RS2: begin
				a_q <= rvalid_q[insn_q[19:15]] ? rf_rdata : 64'd0;
			end
			ST_EXEC: begin
				acc_q  <= 64'd0;
				inr_q  <= 1'b0;
				base_q <= ex_base;
				n_q    <= ex_n;
				wdat_q <= b_c;
				bk_q   <= BK_DATA;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			pc_q     <= 64'd0;
			rvalid_q <= 32'd0;
			clr_q    <= '0;
			cnt_q    <= 4'd0;
		end else begin
			if (rf_we) begin
				rvalid_q[rf_waddr] <= 1'b1;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= rvi_pkg::mem_addr_t'(clr_q + 1'b1);
					if (clr_q == rvi_pkg::mem_addr_t'(rvi_pkg::MEM_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= 4'd0;
					if (item_valid) begin
						unique case (item.kind) inside
							rvi_pkg::IK_EXEC, rvi_pkg::IK_HREAD: state_q <= ST_BYTE_RD;
							rvi_pkg::IK_HWRITE:                  state_q <= ST_BYTE_WR;
							default:                             state_q <= ST_DONE;
						endcase
					end
				end
				ST_BYTE_RD: begin
					if (rd_last) begin
						cnt_q <= 4'd0;
						case (bk_q)
							BK_INSN: state_q <= ST_RS1;
							BK_DATA: begin
								pc_q    <= pc4;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_BYTE_WR: begin
					if (wr_last) begin
						cnt_q   <= 4'd0;
						state_q <= ST_DONE;
						if (bk_q == BK_DATA) begin
							pc_q <= pc4;
						end
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_RS1: state_q <= ST_RS2;
				ST_RS2: state_q <= ST_EXEC;
				ST_EXEC: begin
					cnt_q <= 4'd0;
					if (ex_illegal) begin
						state_q <= ST_DONE;
					end else if (ex_load) begin
						state_q <= ST_BYTE_RD;
					end else if (ex_store) begin
						state_q <= ST_BYTE_WR;
					end else begin
						pc_q    <= ex_npc;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign item_take = (state_q == ST_IDLE) && item_valid;
	assign res_push  = (state_q == ST_DONE) && !res_full;
	assign clearing  = (state_q == ST_CLEAR);
	assign res       = res_q;
endmodule

// File: tb/rv64i_integer_core_step_tb.sv
// Self-checking testbench for the RV64I step core: loads instructions by host writes,
// executes them and checks every result word against a built-in core predictor.
// Depends on rvi_pkg and rv64i_integer_core_step.
`timescale 1ns / 100ps
module rv64i_integer_core_step_tb;
	localparam logic [1:0] FN_NONE = 2'd3;
	localparam int N_ITEMS = 1300;
	localparam int IDLE_LIMIT = 300000;  // covers the memory clear after reset
	localparam logic [63:0] PC_CEIL = 64'hFFF0;
	localparam logic [31:0] NOP = {12'd0, 5'd0, rvi_pkg::F3_ADD, 5'd0, rvi_pkg::OPC_OPIMM};

	typedef struct {
		logic [1:0]  fn;
		logic [15:0] addr;
		logic [63:0] data;
	} host_word_t;

	logic clk, arst_n, push, full, empty, pop;
	logic [1:0] func;
	logic [15:0] host_addr;
	logic [63:0] host_data;
	logic ok, cause;
	logic [63:0] pc_now, read_data, wb_value;
	logic [4:0] wb_index;

	rv64i_integer_core_step DUT (.*);

	// predicted architectural state
	logic [7:0]  core_mem [0:rvi_pkg::MEM_BYTES-1];
	logic [63:0] xreg [0:31];
	logic [63:0] core_pc;

	host_word_t         pending_words[$];
	rvi_pkg::result_t   expected_results[$];
	int errors, n_exec, n_trap, n_host, n_checked;
	bit push_taken, long_hold_done;
	int burst_left, gap_left, hold_left, idle_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] sext(logic [63:0] v, int bits);
		logic [63:0] m, mask;
		m = 64'd1 << (bits - 1);
		mask = (64'd1 << bits) - 64'd1;
		return ((v & mask) ^ m) - m;
	endfunction

	function automatic logic [63:0] mem_load(logic [63:0] addr, int n);
		logic [63:0] v, a;
		v = '0;
		for (int i = 0; i < n; i++) begin
			a = addr + i;
			if (a < rvi_pkg::MEM_BYTES) v |= 64'(core_mem[a]) << (8 * i);
		end
		return v;
	endfunction

	function automatic void mem_store(logic [63:0] addr, int n, logic [63:0] v);
		logic [63:0] a;
		for (int i = 0; i < n; i++) begin
			a = addr + i;
			if (a < rvi_pkg::MEM_BYTES) core_mem[a] = v[8*i +: 8];
		end
	endfunction

	function automatic rvi_pkg::result_t core_step(logic [1:0] fn, logic [15:0] ha,
		logic [63:0] hd);
		rvi_pkg::result_t r;
		logic [31:0] insn;
		logic [6:0] opc, f7;
		logic [4:0] rd;
		logic [2:0] f3;
		logic [5:0] top6, sh;
		logic [63:0] a, b, immi, npc, res, lo, off;
		bit legal, wr, taken;
		r = '0;
		r.ok = 1'b1;
		if (fn == rvi_pkg::FN_HWRITE) begin
			mem_store(64'(ha), 8, hd);
			n_host++;
		end else if (fn == rvi_pkg::FN_HREAD) begin
			r.read_data = mem_load(64'(ha), 8);
			n_host++;
		end else if (fn == rvi_pkg::FN_EXEC) begin
			n_exec++;
			insn = mem_load(core_pc, 4);
			opc = insn[6:0]; rd = insn[11:7]; f3 = insn[14:12];
			f7 = insn[31:25]; top6 = insn[31:26];
			a = xreg[insn[19:15]]; b = xreg[insn[24:20]];
			immi = sext(64'(insn[31:20]), 12);
			npc = core_pc + 4; res = '0; wr = 1; legal = 1;
			lo = {32'd0, a[31:0]};
			case (opc)
				rvi_pkg::OPC_LUI: res = sext(64'(insn & 32'hFFFFF000), 32);
				rvi_pkg::OPC_AUIPC: res = core_pc + sext(64'(insn & 32'hFFFFF000), 32);
				rvi_pkg::OPC_JAL: begin
					off = 64'({insn[31], insn[19:12], insn[20], insn[30:21], 1'b0});
					res = core_pc + 4;
					npc = core_pc + sext(off, 21);
				end
				rvi_pkg::OPC_JALR: begin
					if (f3 != rvi_pkg::F3_JALR) legal = 0;
					res = core_pc + 4;
					npc = (a + immi) & ~64'd1;
				end
				rvi_pkg::OPC_BRANCH: begin
					off = 64'({insn[31], insn[7], insn[30:25], insn[11:8], 1'b0});
					taken = 0;
					case (f3)
						rvi_pkg::F3_BEQ: taken = (a == b);
						rvi_pkg::F3_BNE: taken = (a != b);
						rvi_pkg::F3_BLT: taken = ($signed(a) < $signed(b));
						rvi_pkg::F3_BGE: taken = !($signed(a) < $signed(b));
						rvi_pkg::F3_BLTU: taken = (a < b);
						rvi_pkg::F3_BGEU: taken = (a >= b);
						default: legal = 0;
					endcase
					if (taken) npc = core_pc + sext(off, 13);
					wr = 0;
				end
				rvi_pkg::OPC_LOAD: begin
					if (f3 == rvi_pkg::F3_BAD) legal = 0;
					else begin
						res = mem_load(a + immi, 1 << f3[1:0]);
						if (f3 < 3) res = sext(res, 8 << f3[1:0]);
					end
				end
				rvi_pkg::OPC_STORE: begin
					if (f3 > 3) legal = 0;
					else mem_store(a + sext(64'({insn[31:25], insn[11:7]}), 12), 1 << f3, b);
					wr = 0;
				end
				rvi_pkg::OPC_OPIMM: begin
					sh = insn[25:20];
					case (f3)
						rvi_pkg::F3_ADD: res = a + immi;
						rvi_pkg::F3_SLT: res = 64'($signed(a) < $signed(immi));
						rvi_pkg::F3_SLTU: res = 64'(a < immi);
						rvi_pkg::F3_XOR: res = a ^ immi;
						rvi_pkg::F3_OR: res = a | immi;
						rvi_pkg::F3_AND: res = a & immi;
						rvi_pkg::F3_SLL: begin
							if (top6 != rvi_pkg::TOP6_SRL) legal = 0;
							res = a << sh;
						end
						default: begin
							if (top6 == rvi_pkg::TOP6_SRL) res = a >> sh;
							else if (top6 == rvi_pkg::TOP6_SRA) res = $signed(a) >>> sh;
							else legal = 0;
						end
					endcase
				end
				rvi_pkg::OPC_OP: begin
					sh = b[5:0];
					if (f7 == rvi_pkg::F7_ALT) begin
						if (f3 == rvi_pkg::F3_ADD) res = a - b;
						else if (f3 == rvi_pkg::F3_SR) res = $signed(a) >>> sh;
						else legal = 0;
					end else if (f7 == rvi_pkg::F7_BASE) begin
						case (f3)
							rvi_pkg::F3_ADD: res = a + b;
							rvi_pkg::F3_SLL: res = a << sh;
							rvi_pkg::F3_SLT: res = 64'($signed(a) < $signed(b));
							rvi_pkg::F3_SLTU: res = 64'(a < b);
							rvi_pkg::F3_XOR: res = a ^ b;
							rvi_pkg::F3_SR: res = a >> sh;
							rvi_pkg::F3_OR: res = a | b;
							default: res = a & b;
						endcase
					end else legal = 0;
				end
				rvi_pkg::OPC_OPIMM32, rvi_pkg::OPC_OP32: begin
					sh = (opc == rvi_pkg::OPC_OP32) ? {1'b0, b[4:0]} : {1'b0, insn[24:20]};
					if (f3 == rvi_pkg::F3_ADD && opc == rvi_pkg::OPC_OPIMM32)
						res = sext(a + immi, 32);
					else if (f3 == rvi_pkg::F3_ADD && f7 == rvi_pkg::F7_BASE)
						res = sext(a + b, 32);
					else if (f3 == rvi_pkg::F3_ADD && f7 == rvi_pkg::F7_ALT)
						res = sext(a - b, 32);
					else if (f3 == rvi_pkg::F3_SLL && f7 == rvi_pkg::F7_BASE)
						res = sext(lo << sh, 32);
					else if (f3 == rvi_pkg::F3_SR && f7 == rvi_pkg::F7_BASE)
						res = sext(lo >> sh, 32);
					else if (f3 == rvi_pkg::F3_SR && f7 == rvi_pkg::F7_ALT)
						res = $signed(sext(lo, 32)) >>> sh;
					else legal = 0;
				end
				default: legal = 0;
			endcase
			if (legal) begin
				if (wr && rd != 0) begin
					xreg[rd] = res;
					r.wb_index = rd;
					r.wb_value = res;
				end
				core_pc = npc;
			end else begin
				r.ok = 1'b0;
				r.cause = 1'b1;
				n_trap++;
			end
		end
		r.pc_now = core_pc;
		return r;
	endfunction

	function automatic void add_word(logic [1:0] fn, logic [15:0] ha, logic [63:0] hd);
		host_word_t w;
		w.fn = fn; w.addr = ha; w.data = hd;
		pending_words.push_back(w);
		expected_results.push_back(core_step(fn, ha, hd));
	endfunction

	// plant an instruction at pc, then run it
	function automatic void run_insn(logic [31:0] insn);
		logic [63:0] d;
		d = mem_load(core_pc, 8);
		d[31:0] = insn;
		add_word(rvi_pkg::FN_HWRITE, core_pc[15:0], d);
		add_word(rvi_pkg::FN_EXEC, '0, '0);
	endfunction

	function automatic logic [4:0] pick_reg();
		return ($urandom_range(0, 99) < 40) ? 5'd0 : 5'($urandom);
	endfunction

	function automatic logic [31:0] gen_insn();
		logic [31:0] i;
		logic [4:0] rs1, rs2, rd;
		logic [2:0] f3;
		logic [6:0] f7;
		logic [11:0] imm;
		logic [63:0] tgt;
		int k;
		rs1 = pick_reg(); rs2 = pick_reg(); rd = 5'($urandom);
		f3 = 3'($urandom); imm = 12'($urandom);
		k = $urandom_range(0, 3);
		f7 = (k == 0) ? rvi_pkg::F7_BASE : (k == 1) ? rvi_pkg::F7_ALT :
			(k == 2) ? rvi_pkg::F7_BASE : 7'($urandom);
		case ($urandom_range(0, 15))
			0: i = {20'($urandom), rd, rvi_pkg::OPC_LUI};
			1: i = {20'($urandom), rd, rvi_pkg::OPC_AUIPC};
			2: i = {1'b0, 10'($urandom_range(0, 40)), 1'b0, 8'd0, rd, rvi_pkg::OPC_JAL} ^
				($urandom_range(0, 1) ? 32'h0 : 32'hFFE0_0000);
			3: i = {imm, rs1, ($urandom_range(0, 7) == 0) ? f3 : rvi_pkg::F3_JALR, rd,
				rvi_pkg::OPC_JALR};
			4: i = {imm[11], 6'($urandom), rs2, rs1, f3, 4'($urandom), imm[0],
				rvi_pkg::OPC_BRANCH};
			5, 6: i = {imm, rs1, f3, rd, rvi_pkg::OPC_LOAD};
			7, 8: i = {7'($urandom), rs2, rs1, f3 & ($urandom_range(0, 7) ? 3'd3 : 3'd7),
				5'($urandom), rvi_pkg::OPC_STORE};
			9, 10: begin
				if (f3 == rvi_pkg::F3_SLL || f3 == rvi_pkg::F3_SR) begin
					k = $urandom_range(0, 7);
					imm[11:6] = (k < 4) ? rvi_pkg::TOP6_SRL :
						(k < 7) ? rvi_pkg::TOP6_SRA : 6'($urandom);
				end
				i = {imm, rs1, f3, rd, rvi_pkg::OPC_OPIMM};
			end
			11, 12: i = {f7, rs2, rs1, f3, rd, rvi_pkg::OPC_OP};
			13: i = {f7, 5'($urandom), rs1, f3, rd, rvi_pkg::OPC_OPIMM32};
			14: i = {f7, rs2, rs1, f3, rd, rvi_pkg::OPC_OP32};
			default: i = $urandom;
		endcase
		// keep pc inside memory, else every later fetch reads zero
		tgt = core_pc;
		if (i[6:0] == rvi_pkg::OPC_JAL)
			tgt = core_pc + sext(64'({i[31], i[19:12], i[20], i[30:21], 1'b0}), 21);
		else if (i[6:0] == rvi_pkg::OPC_BRANCH)
			tgt = core_pc + sext(64'({i[31], i[7], i[30:25], i[11:8], 1'b0}), 13);
		else if (i[6:0] == rvi_pkg::OPC_JALR)
			tgt = xreg[i[19:15]] + sext(64'(i[31:20]), 12);
		if (tgt >= PC_CEIL || core_pc + 4 >= PC_CEIL) i = NOP;
		return i;
	endfunction

	initial begin
		logic [31:0] w;
		int r;
		for (int i = 0; i < rvi_pkg::MEM_BYTES; i++) core_mem[i] = '0;
		for (int i = 0; i < 32; i++) xreg[i] = '0;
		core_pc = '0;
		push = 0; pop = 0; func = '0; host_addr = '0; host_data = '0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: empty memory traps, host word edges, then a few instructions
		add_word(rvi_pkg::FN_EXEC, '0, '0);
		add_word(rvi_pkg::FN_HWRITE, 16'hFFF8, '1);
		add_word(rvi_pkg::FN_HWRITE, 16'hFFFF, 64'hA5A5_5A5A_0F0F_F0F0);
		add_word(rvi_pkg::FN_HREAD, 16'hFFF8, '0);
		add_word(rvi_pkg::FN_HREAD, 16'hFFFF, '0);
		add_word(FN_NONE, 16'hFFFF, '1);
		add_word(rvi_pkg::FN_HREAD, 16'h0000, '0);
		run_insn({12'hFFF, 5'd0, rvi_pkg::F3_ADD, 5'd1, rvi_pkg::OPC_OPIMM});
		run_insn({20'h80000, 5'd2, rvi_pkg::OPC_LUI});
		run_insn({12'hFFE, 5'd0, 3'd3, 5'd3, rvi_pkg::OPC_LOAD});
		run_insn({12'h7FF, 5'd1, rvi_pkg::F3_ADD, 5'd0, rvi_pkg::OPC_OPIMM});
		run_insn({7'h01, 5'd1, 5'd2, 3'd3, 5'd0, rvi_pkg::OPC_STORE});
		run_insn({rvi_pkg::TOP6_SRA, 6'd63, 5'd2, rvi_pkg::F3_SR, 5'd4, rvi_pkg::OPC_OPIMM});
		run_insn({rvi_pkg::F7_ALT, 5'd31, 5'd2, rvi_pkg::F3_SR, 5'd5, rvi_pkg::OPC_OPIMM32});
		run_insn({12'd0, 5'd0, rvi_pkg::F3_BAD, 5'd0, rvi_pkg::OPC_LOAD});
		run_insn(32'h0000_000F);

		while (pending_words.size() < N_ITEMS) begin
			r = $urandom_range(0, 99);
			w = mem_load(core_pc, 4);
			if (r < 60) run_insn(gen_insn());
			else if (r < 72) begin
				if (w[6:0] == rvi_pkg::OPC_JAL || w[6:0] == rvi_pkg::OPC_JALR ||
					w[6:0] == rvi_pkg::OPC_BRANCH || core_pc + 4 >= PC_CEIL)
					run_insn(gen_insn());
				else add_word(rvi_pkg::FN_EXEC, 16'($urandom), $urandom);
			end else if (r < 82)
				add_word(rvi_pkg::FN_HREAD, $urandom_range(0, 1) ?
					16'($urandom_range(0, 4095)) : 16'($urandom), '0);
			else if (r < 92)
				add_word(rvi_pkg::FN_HWRITE, 16'($urandom), {$urandom, $urandom});
			else add_word(FN_NONE, 16'($urandom), {$urandom, $urandom});
		end

		while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Ran %0d instructions (%0d trapped) and %0d host words; %0d results checked.",
			n_exec, n_trap, n_host, n_checked);
		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

	// sender: bursts with gaps
	always @(posedge clk) push_taken <= push && !full;

	always @(negedge clk) begin
		bit drive;
		if (arst_n) begin
			if (push_taken) void'(pending_words.pop_front());
			drive = 0;
			if (gap_left > 0) gap_left <= gap_left - 1;
			else if (pending_words.size() > 0 && !(push_taken && pending_words.size() == 0)) begin
				drive = 1;
				if (burst_left > 0) burst_left <= burst_left - 1;
				else begin
					burst_left <= $urandom_range(0, 1) ? $urandom_range(1, 40) : 1;
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
				end
			end
			push <= drive;
			if (drive) begin
				func <= pending_words[0].fn;
				host_addr <= pending_words[0].addr;
				host_data <= pending_words[0].data;
			end
		end
	end

	// receiver: random stalls, one long hold to back the core up
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				pop <= 0;
			end else if (!long_hold_done && n_checked == 150) begin
				long_hold_done <= 1;
				hold_left <= 400;
				pop <= 0;
			end else if (n_checked % 200 < 100) pop <= ($urandom_range(0, 99) < 70);
			else pop <= 1;
		end
	end

	// checker and watchdog
	always @(posedge clk) begin
		rvi_pkg::result_t e;
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles > IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
			if (pop && !empty) begin
				n_checked <= n_checked + 1;
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (ok !== e.ok) begin
						$error("ok exp %0h got %0h", e.ok, ok); errors++;
					end
					if (cause !== e.cause) begin
						$error("cause exp %0h got %0h", e.cause, cause); errors++;
					end
					if (pc_now !== e.pc_now) begin
						$error("pc_now exp %h got %h", e.pc_now, pc_now); errors++;
					end
					if (read_data !== e.read_data) begin
						$error("read_data exp %h got %h", e.read_data, read_data); errors++;
					end
					if (wb_index !== e.wb_index) begin
						$error("wb_index exp %0d got %0d", e.wb_index, wb_index); errors++;
					end
					if (wb_value !== e.wb_value) begin
						$error("wb_value exp %h got %h", e.wb_value, wb_value); errors++;
					end
				end
			end
		end
	end
endmodule

// File: sim.f
+incdir+hdl
hdl/rvi_pkg.sv
hdl/rvi_ram.sv
hdl/rvi_front.sv
hdl/rvi_resq.sv
hdl/rvi_back.sv
hdl/rv64i_integer_core_step.sv
tb/rv64i_integer_core_step_tb.sv
